// ===== hw/rtl/cdd_pkg.sv =====
package cdd_pkg;

   // Unit codes carried in the operation field.
   localparam logic [2:0] OP_DAYS    = 3'd0;
   localparam logic [2:0] OP_WEEKS   = 3'd1;
   localparam logic [2:0] OP_MONTHS  = 3'd2;
   localparam logic [2:0] OP_YEARS   = 3'd3;
   localparam logic [2:0] OP_DECADES = 3'd4;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   // Multiplicative inverse of 25 modulo 2^16 and the divisibility bound.
   localparam logic [15:0] INV25_16    = 16'd23593;
   localparam logic [15:0] DIV25_BOUND = 16'd2621;

   typedef struct packed {
      logic [2:0]         operation;
      logic [14:0]        count;
      logic signed [15:0] year_in;
      logic [3:0]         month_in;
      logic [4:0]         day_in;
   } req_type;

   typedef struct packed {
      logic signed [15:0] year_out;
      logic [3:0]         month_out;
      logic [4:0]         day_out;
   } rsp_type;

   // Gregorian rule on the signed year. Divisibility by 25 of the magnitude
   // uses the odd-divisor inverse test, so only one 16-bit multiply is needed.
   function automatic logic is_leap(input logic [15:0] year);
      logic [15:0] mag;
      logic [15:0] prod;
      logic        div4;
      logic        div16;
      logic        div25;
      mag   = year[15] ? (16'd0 - year) : year;
      prod  = mag * INV25_16;
      div4  = (year[1:0] == 2'd0);
      div16 = (year[3:0] == 4'd0);
      div25 = (prod <= DIV25_BOUND);
      return (div4 && !div25) || (div16 && div25);
   endfunction

   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         MONTH_FEB: begin
            len = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

endpackage

// ===== hw/rtl/calendar_date_decrement.sv =====
// Moves a Gregorian date back by a count of days, weeks, months, years or
// decades and returns one result per request. Out-of-range months are clamped
// to 1..12 and the day to 1..length of that month before the step; unknown
// operations return that corrected date. One request is handled at a time and
// req_ready is high only while the engine is idle. A year or decade request
// subtracts its years in one step. A day or week request walks back one month
// at a time; each month crossing goes through the shared previous-month
// stepper and then waits for the registered leap-year flag of the new year
// before the month length is known. A month request steps back one month at a
// time (a whole year at a time once the day is 28 or less), and goes through
// that leap wait for each month while the day is still above 28 and must be
// clamped. A finished result is held in an output register, so the next
// request is accepted while the previous result waits on rsp_ready.
module calendar_date_decrement (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cdd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cdd_pkg::rsp_type rsp_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_WAIT   = 3'd1;
   localparam logic [2:0] ST_LEN    = 3'd2;
   localparam logic [2:0] ST_START  = 3'd3;
   localparam logic [2:0] ST_DAYS   = 3'd4;
   localparam logic [2:0] ST_MONTHS = 3'd5;
   localparam logic [2:0] ST_FIN    = 3'd6;

   localparam logic [4:0]  CLAMP_FREE_DAY  = 5'd28;
   localparam logic [14:0] MONTHS_PER_YEAR = 15'd12;

   logic [2:0]       state_ff, state_in;
   logic             init_ff, init_in;
   logic [2:0]       op_ff, op_in;
   logic [14:0]      cnt_ff, cnt_in;
   logic [17:0]      rem_ff, rem_in;
   logic [15:0]      yr_ff, yr_in;
   logic [3:0]       mon_ff, mon_in;
   logic [4:0]       day_ff, day_in;
   logic             leap_ff, leap_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cdd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Shared year subtractor and previous-month stepper.
   logic [15:0] year_sub;
   logic [15:0] year_diff;
   logic [3:0]  prev_mon;
   logic        prev_wrap;
   logic [4:0]  cur_len;
   logic [17:0] weeks_days;
   logic [17:0] decade_years;
   logic [3:0]  mon_clamped;

   assign year_diff    = yr_ff - year_sub;
   assign prev_wrap    = (mon_ff <= cdd_pkg::MONTH_JAN);
   assign prev_mon     = prev_wrap ? cdd_pkg::MONTH_DEC : (mon_ff - 4'd1);
   assign cur_len      = cdd_pkg::month_length(mon_ff, leap_ff);
   assign weeks_days   = {cnt_ff, 3'b000} - {3'b000, cnt_ff};
   assign decade_years = {cnt_ff, 3'b000} + {2'b00, cnt_ff, 1'b0};
   assign leap_in      = cdd_pkg::is_leap(yr_ff);

   always_comb begin
      if (req_data.month_in < cdd_pkg::MONTH_JAN) begin
         mon_clamped = cdd_pkg::MONTH_JAN;
      end else if (req_data.month_in > cdd_pkg::MONTH_DEC) begin
         mon_clamped = cdd_pkg::MONTH_DEC;
      end else begin
         mon_clamped = req_data.month_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      yr_in        = yr_ff;
      mon_in       = mon_ff;
      day_in       = day_ff;
      year_sub     = 16'd0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.operation;
               cnt_in   = req_data.count;
               yr_in    = req_data.year_in;
               mon_in   = mon_clamped;
               day_in   = (req_data.day_in == 5'd0) ? 5'd1 : req_data.day_in;
               init_in  = 1'b1;
               state_in = ST_WAIT;
            end
         end
         // Lets the leap flag settle on the current year.
         ST_WAIT: begin
            state_in = ST_LEN;
         end
         ST_LEN: begin
            if (init_ff) begin
               if (day_ff > cur_len) begin
                  day_in = cur_len;
               end
               init_in  = 1'b0;
               state_in = ST_START;
            end else if (op_ff == cdd_pkg::OP_DAYS || op_ff == cdd_pkg::OP_WEEKS) begin
               day_in   = cur_len;
               state_in = ST_DAYS;
            end else begin
               if (day_ff > cur_len) begin
                  day_in = cur_len;
               end
               state_in = ST_MONTHS;
            end
         end
         ST_START: begin
            case (op_ff)
               cdd_pkg::OP_DAYS: begin
                  rem_in   = {3'b000, cnt_ff};
                  state_in = ST_DAYS;
               end
               cdd_pkg::OP_WEEKS: begin
                  rem_in   = weeks_days;
                  state_in = ST_DAYS;
               end
               cdd_pkg::OP_MONTHS: begin
                  state_in = ST_MONTHS;
               end
               cdd_pkg::OP_YEARS: begin
                  year_sub = {1'b0, cnt_ff};
                  yr_in    = year_diff;
                  state_in = ST_FIN;
               end
               cdd_pkg::OP_DECADES: begin
                  year_sub = decade_years[15:0];
                  yr_in    = year_diff;
                  state_in = ST_FIN;
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_DAYS: begin
            if (rem_ff >= {13'd0, day_ff}) begin
               rem_in   = rem_ff - {13'd0, day_ff};
               mon_in   = prev_mon;
               year_sub = {15'd0, prev_wrap};
               yr_in    = year_diff;
               state_in = ST_WAIT;
            end else begin
               day_in   = day_ff - rem_ff[4:0];
               state_in = ST_FIN;
            end
         end
         ST_MONTHS: begin
            if (cnt_ff == 15'd0) begin
               state_in = ST_FIN;
            end else if (day_ff > CLAMP_FREE_DAY) begin
               // The day may exceed the new month, so clamp after the step.
               mon_in   = prev_mon;
               year_sub = {15'd0, prev_wrap};
               yr_in    = year_diff;
               cnt_in   = cnt_ff - 15'd1;
               state_in = ST_WAIT;
            end else if (cnt_ff >= MONTHS_PER_YEAR) begin
               year_sub = 16'd1;
               yr_in    = year_diff;
               cnt_in   = cnt_ff - MONTHS_PER_YEAR;
            end else begin
               mon_in   = prev_mon;
               year_sub = {15'd0, prev_wrap};
               yr_in    = year_diff;
               cnt_in   = cnt_ff - 15'd1;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.year_out  = yr_ff;
               rsp_data_in.month_out = mon_ff;
               rsp_data_in.day_out   = day_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      yr_ff       <= yr_in;
      mon_ff      <= mon_in;
      day_ff      <= day_in;
      leap_ff     <= leap_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_WAIT && init_ff))
      else $error("accepted transaction did not start the leap wait");

   a_day_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (day_ff != 5'd0))
      else $error("working day register reached zero");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (mon_ff >= cdd_pkg::MONTH_JAN && mon_ff <= cdd_pkg::MONTH_DEC))
      else $error("working month out of range");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FIN))
      else $error("result overwritten before the previous transaction was taken");

   a_rsp_date_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.day_out != 5'd0 &&
                        rsp_data_ff.month_out >= cdd_pkg::MONTH_JAN &&
                        rsp_data_ff.month_out <= cdd_pkg::MONTH_DEC))
      else $error("result date out of range");

endmodule

// ===== verif/calendar_date_decrement_tb.sv =====
`timescale 1ns / 100ps

module calendar_date_decrement_tb;

   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
   localparam int         STALL_LIMIT     = 100000;
   localparam int         DRAIN_CYCLES    = 20;

   class date_scoreboard;
      cdd_pkg::rsp_type expected_dates[$];
      int unsigned      errors;
      int               month_len_table[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

      // The leap rule is applied to the signed year, so negative centuries count too.
      function bit leap(logic [15:0] y);
         int v;
         v = $signed(y);
         return ((v % 4 == 0) && (v % 100 != 0)) || (v % 400 == 0);
      endfunction

      function int days_of(int m, logic [15:0] y);
         if (m == cdd_pkg::MONTH_FEB) begin
            return leap(y) ? 29 : 28;
         end
         return month_len_table[m - 1];
      endfunction

      function void step_back_month(inout int m, inout logic [15:0] y);
         if (m <= cdd_pkg::MONTH_JAN) begin
            m = cdd_pkg::MONTH_DEC;
            y = y - 16'd1;
         end else begin
            m = m - 1;
         end
      endfunction

      function cdd_pkg::rsp_type shifted_date(cdd_pkg::req_type r);
         logic [15:0]      y;
         int               m;
         int               d;
         int               cnt;
         int               rem;
         int               yrs;
         cdd_pkg::rsp_type res;
         y   = r.year_in;
         m   = r.month_in;
         d   = r.day_in;
         cnt = r.count;
         if (m < cdd_pkg::MONTH_JAN) m = cdd_pkg::MONTH_JAN;
         if (m > cdd_pkg::MONTH_DEC) m = cdd_pkg::MONTH_DEC;
         if (d < 1) d = 1;
         if (d > days_of(m, y)) d = days_of(m, y);
         case (r.operation)
            cdd_pkg::OP_DAYS, cdd_pkg::OP_WEEKS: begin
               rem = (r.operation == cdd_pkg::OP_WEEKS) ? cnt * 7 : cnt;
               while (rem >= d) begin
                  rem = rem - d;
                  step_back_month(m, y);
                  d = days_of(m, y);
               end
               d = d - rem;
            end
            cdd_pkg::OP_MONTHS: begin
               // Only a day above 28 can need clamping; once it is 28 or less, whole
               // months can be taken off arithmetically.
               while (cnt > 0 && d > 28) begin
                  step_back_month(m, y);
                  if (d > days_of(m, y)) d = days_of(m, y);
                  cnt--;
               end
               m = m - 1 - cnt;
               if (m < 0) begin
                  yrs = (11 - m) / 12;
                  m   = m + 12 * yrs;
                  y   = y - 16'(yrs);
               end
               m = m + 1;
            end
            cdd_pkg::OP_YEARS: begin
               y = y - 16'(cnt);
            end
            cdd_pkg::OP_DECADES: begin
               y = y - 16'(cnt * 10);
            end
            default: begin
            end
         endcase
         res.year_out  = y;
         res.month_out = 4'(m);
         res.day_out   = 5'(d);
         return res;
      endfunction

      function void note_request(cdd_pkg::req_type r);
         expected_dates.push_back(shifted_date(r));
      endfunction

      function void check_result(cdd_pkg::rsp_type got);
         cdd_pkg::rsp_type want;
         if (expected_dates.size() == 0) begin
            $display("%0t: unexpected result %0d-%0d-%0d with no request pending", $time,
                     got.year_out, got.month_out, got.day_out);
            errors++;
            return;
         end
         want = expected_dates.pop_front();
         if (got.year_out !== want.year_out) begin
            $display("%0t: year_out expected %0d, actual %0d", $time, want.year_out,
                     got.year_out);
            errors++;
         end
         if (got.month_out !== want.month_out) begin
            $display("%0t: month_out expected %0d, actual %0d", $time, want.month_out,
                     got.month_out);
            errors++;
         end
         if (got.day_out !== want.day_out) begin
            $display("%0t: day_out expected %0d, actual %0d", $time, want.day_out,
                     got.day_out);
            errors++;
         end
      endfunction

      function int pending();
         return expected_dates.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   cdd_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   cdd_pkg::rsp_type rsp_data;

   date_scoreboard sb;
   int             send_idle_pct;
   int             recv_idle_pct;
   int             stalled_cycles;

   calendar_date_decrement u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
      end
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic cdd_pkg::req_type date_req(logic [2:0] op, int cnt, int year, int month,
                                                 int day);
      return cdd_pkg::req_type'{op, 15'(cnt), 16'(year), 4'(month), 5'(day)};
   endfunction

   // Most day, week and month counts stay small so the walks finish quickly; a few span
   // the whole field, as do half of the other counts.
   function automatic cdd_pkg::req_type random_request();
      cdd_pkg::req_type r;
      int               pick;
      pick = $urandom_range(99);
      if (pick < 5) begin
         r.operation = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      end else begin
         r.operation = 3'($urandom_range(cdd_pkg::OP_DECADES, cdd_pkg::OP_DAYS));
      end
      pick = $urandom_range(99);
      case (r.operation)
         cdd_pkg::OP_DAYS: begin
            r.count = (pick < 2) ? 15'($urandom) :
                      (pick < 15) ? 15'($urandom_range(1000)) : 15'($urandom_range(60));
         end
         cdd_pkg::OP_WEEKS: begin
            r.count = (pick < 2) ? 15'($urandom) :
                      (pick < 15) ? 15'($urandom_range(150)) : 15'($urandom_range(10));
         end
         cdd_pkg::OP_MONTHS: begin
            r.count = (pick < 10) ? 15'($urandom) : 15'($urandom_range(100));
         end
         default: begin
            r.count = (pick < 50) ? 15'($urandom) : 15'($urandom_range(100));
         end
      endcase
      pick = $urandom_range(99);
      if (pick < 50) begin
         r.year_in = 16'($urandom);
      end else if (pick < 75) begin
         r.year_in = 16'($urandom_range(2100, 1890));
      end else begin
         r.year_in = 16'($urandom_range(654) * 100 - 32700);
      end
      pick = $urandom_range(99);
      r.month_in = (pick < 90) ? 4'($urandom_range(12, 1)) : 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 40) begin
         r.day_in = 5'($urandom_range(31, 27));
      end else if (pick < 80) begin
         r.day_in = 5'($urandom_range(31, 1));
      end else begin
         r.day_in = 5'($urandom_range(31));
      end
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_request(input cdd_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic send_random(input int n);
      repeat (n) begin
         send_request(random_request());
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      stalled_cycles = 0;
      send_idle_pct  = 6;
      recv_idle_pct  = 80;
      sb             = new();
      repeat (10) @(negedge clock);
      reset = 1'b0;

      send_request(date_req(cdd_pkg::OP_DAYS, 0, 2024, 3, 15));
      send_request(date_req(cdd_pkg::OP_DAYS, 1, -32768, cdd_pkg::MONTH_JAN, 1));
      send_request(date_req(cdd_pkg::OP_DAYS, 1, 2024, 3, 1));
      send_request(date_req(cdd_pkg::OP_DAYS, 1, 1900, 3, 1));
      send_request(date_req(cdd_pkg::OP_DAYS, 1, 2000, 3, 1));
      send_request(date_req(cdd_pkg::OP_DAYS, 1, -100, 3, 1));
      send_request(date_req(cdd_pkg::OP_DAYS, 1, -400, 3, 1));
      send_request(date_req(cdd_pkg::OP_DAYS, 32767, 32767, cdd_pkg::MONTH_DEC, 31));
      send_request(date_req(cdd_pkg::OP_WEEKS, 1, 2023, 3, 3));
      send_request(date_req(cdd_pkg::OP_WEEKS, 32767, 100, 6, 15));
      send_request(date_req(cdd_pkg::OP_MONTHS, 1, 2024, 3, 31));
      send_request(date_req(cdd_pkg::OP_MONTHS, 13, 2023, cdd_pkg::MONTH_JAN, 31));
      send_request(date_req(cdd_pkg::OP_MONTHS, 32767, 5, cdd_pkg::MONTH_DEC, 31));
      send_request(date_req(cdd_pkg::OP_MONTHS, 0, 2021, 7, 31));
      send_request(date_req(cdd_pkg::OP_YEARS, 1, 2024, cdd_pkg::MONTH_FEB, 29));
      send_request(date_req(cdd_pkg::OP_YEARS, 32767, -32768, 5, 5));
      send_request(date_req(cdd_pkg::OP_DECADES, 32767, 0, 8, 8));
      send_request(date_req(cdd_pkg::OP_DECADES, 1, 5, 9, 9));
      send_request(date_req(OP_UNUSED_FIRST, 3, 2020, 0, 0));
      send_request(date_req(OP_UNUSED_FIRST + 3'd1, 3, 2020, 15, 31));
      send_request(date_req(OP_UNUSED_LAST, 32767, 2019, 13, 30));
      send_request(date_req(cdd_pkg::OP_DAYS, 5, 2022, 0, 0));
      send_request(date_req(cdd_pkg::OP_MONTHS, 2, 2022, 15, 31));
      send_request(date_req(cdd_pkg::OP_DAYS, 2, 2023, 4, 31));
      send_request(date_req(cdd_pkg::OP_YEARS, 3, -4, cdd_pkg::MONTH_FEB, 30));

      send_random(500);
      wait_drained();

      send_idle_pct = 80;
      recv_idle_pct = 6;
      send_random(600);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(580);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
